FILE: design/temp_sensor_scratchpad_check_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scratchpad read checker
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef TEMP_SENSOR_SCRATCHPAD_CHECK_DEFINES_SVH
`define TEMP_SENSOR_SCRATCHPAD_CHECK_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TSSC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tssc check failed");

// consequent must hold in the cycle after the antecedent
`define TSSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tssc check failed");

`endif

FILE: design/tssc_pkg.sv
// ----------------------------------------------------------------------------
// Scratchpad read checker package
// Word types, status codes, marker values and CRC constants.
// ----------------------------------------------------------------------------
package tssc_pkg;

   localparam logic [7:0]  CRC_XOR      = 8'h18;
   localparam logic [7:0]  CRC_TOP      = 8'h80;
   localparam logic [15:0] MARK_CONVERT = 16'(2 * 99);
   localparam logic [15:0] MARK_READ    = 16'(2 * 98);
   localparam logic [15:0] MARK_CRC     = 16'(2 * 97);
   localparam logic [3:0]  LAST_COUNT   = 4'd8;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_CONV   = 2'd1,
      ST_NO_READ   = 2'd2,
      ST_CRC_ERROR = 2'd3
   } status_type;

   typedef enum logic {
      KIND_PRESENCE = 1'b0,
      KIND_BYTE     = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      PH_FIRST  = 3'b001,
      PH_SECOND = 3'b010,
      PH_BYTES  = 3'b100
   } phase_type;

   typedef struct packed {
      kind_type    req_type;
      logic        no_presence;
      logic [7:0]  data_byte;
   } req_word_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] temperature;
   } rsp_word_type;

endpackage

FILE: design/temp_sensor_scratchpad_check.sv
// ----------------------------------------------------------------------------
// Temperature sensor scratchpad read checker
// Follows one read: two presence samples, nine scratchpad bytes, CRC check.
// ----------------------------------------------------------------------------
// Each word is taken into an input register and handled from there; one word
// can be accepted every cycle unless the result register is stalled. A result
// goes from the input register through one result register to rsp; the input
// side stalls only while that register is full and not being taken.
// A presence sample with no device gives status 1 (convert) or 2 (read);
// the ninth byte gives status 0 with the byte1:byte0 temperature, or 3 on a
// CRC mismatch. Bytes outside a read are dropped without a result.
module temp_sensor_scratchpad_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tssc_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tssc_pkg::rsp_word_type rsp_data
);
   import tssc_pkg::*;

   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff,  rsp_word_in;
   phase_type    phase_ff,     phase_in;
   logic [3:0]   count_ff,     count_in;
   logic [7:0]   crc_ff,       crc_in;
   logic [7:0]   temp_low_ff,  temp_low_in;
   logic [7:0]   temp_high_ff, temp_high_in;
   logic [7:0]   crc_upd;
   logic         advance;
   logic         emit;
   rsp_word_type emit_word;

   tssc_crc8 u_crc (
      .crc_cur  (crc_ff),
      .data     (in_word_ff.data_byte),
      .crc_next (crc_upd)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      temp_low_in  = temp_low_ff;
      temp_high_in = temp_high_ff;
      emit         = 1'b0;
      emit_word    = '{status: ST_OK, temperature: 16'd0};
      if (in_word_ff.req_type == KIND_PRESENCE) begin
         if (phase_ff == PH_SECOND) begin
            if (in_word_ff.no_presence) begin
               phase_in  = PH_FIRST;
               emit      = 1'b1;
               emit_word = '{status: ST_NO_READ, temperature: MARK_READ};
            end else begin
               phase_in = PH_BYTES;
               count_in = 4'd0;
               crc_in   = 8'd0;
            end
         end else begin
            // first reset, or a new one that abandons a read
            count_in = 4'd0;
            if (in_word_ff.no_presence) begin
               phase_in  = PH_FIRST;
               emit      = 1'b1;
               emit_word = '{status: ST_NO_CONV, temperature: MARK_CONVERT};
            end else begin
               phase_in = PH_SECOND;
            end
         end
      end else if (phase_ff == PH_BYTES) begin
         if (count_ff < LAST_COUNT) begin
            if (count_ff == 4'd0) begin
               temp_low_in = in_word_ff.data_byte;
            end
            if (count_ff == 4'd1) begin
               temp_high_in = in_word_ff.data_byte;
            end
            crc_in   = crc_upd;
            count_in = count_ff + 4'd1;
         end else begin
            phase_in = PH_FIRST;
            count_in = 4'd0;
            emit     = 1'b1;
            if (crc_ff != in_word_ff.data_byte) begin
               emit_word = '{status: ST_CRC_ERROR, temperature: MARK_CRC};
            end else begin
               emit_word = '{status: ST_OK, temperature: {temp_high_ff, temp_low_ff}};
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = emit_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_FIRST;
         count_ff     <= 4'd0;
         crc_ff       <= 8'd0;
         temp_low_ff  <= 8'd0;
         temp_high_ff <= 8'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            crc_ff       <= crc_in;
            temp_low_ff  <= temp_low_in;
            temp_high_ff <= temp_high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
      rsp_word_ff <= rsp_word_in;
   end

endmodule

FILE: design/tssc_crc8.sv
// ----------------------------------------------------------------------------
// Dallas CRC-8 byte update
// One byte folded into the running CRC, LSB first, eight unrolled steps.
// ----------------------------------------------------------------------------
module tssc_crc8 (
   input  logic [7:0] crc_cur,
   input  logic [7:0] data,
   output logic [7:0] crc_next
);
   import tssc_pkg::*;

   always_comb begin
      logic [7:0] c;
      logic [7:0] d;
      c = crc_cur;
      d = data;
      for (int i = 0; i < 8; i++) begin
         if ((d[0] ^ c[0]) == 1'b1) begin
            c = ((c ^ CRC_XOR) >> 1) | CRC_TOP;
         end else begin
            c = c >> 1;
         end
         d = d >> 1;
      end
      crc_next = c;
   end

endmodule

FILE: design/tssc_checker.sv
// ----------------------------------------------------------------------------
// Scratchpad read checker port assertions
// Watches the top level's ports; bound to every instance of it.
// ----------------------------------------------------------------------------
`include "temp_sensor_scratchpad_check_defines.svh"

module tssc_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_ready,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tssc_pkg::rsp_word_type rsp_data
);
   import tssc_pkg::*;

   `TSSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `TSSC_ASSERT_NOW(a_ready_after_reset, $past(reset), req_ready && !rsp_valid)
   `TSSC_ASSERT_NOW(a_mark_conv, rsp_valid && rsp_data.status == ST_NO_CONV,
                    rsp_data.temperature == MARK_CONVERT)
   `TSSC_ASSERT_NOW(a_mark_read_crc,
                    rsp_valid && (rsp_data.status == ST_NO_READ ||
                                  rsp_data.status == ST_CRC_ERROR),
                    (rsp_data.status == ST_NO_READ && rsp_data.temperature == MARK_READ) ||
                    (rsp_data.status == ST_CRC_ERROR && rsp_data.temperature == MARK_CRC))

endmodule

bind temp_sensor_scratchpad_check tssc_checker u_tssc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
